// ===== design/tro_pkg.sv =====
// Package for the tangent pipeline: fixed-point constants, coefficient values and
// pipeline geometry. It depends on nothing else.
package tro_pkg;

	// Input and result widths.
	localparam int AngleW = 32;
	localparam int TanW   = 32;

	// Internal Q32 working width (integer part up to 16 bits).
	localparam int CoefW = 48;

	// 4/pi in Q1.60, split into the low 32 bits and the upper 29 bits.
	localparam logic [63:0] FourOverPiQ60 = 64'h145F306DC9C882A5;
	localparam logic [31:0] FourOverPiLo  = FourOverPiQ60[31:0];
	localparam logic [28:0] FourOverPiHi  = FourOverPiQ60[60:32];

	// Rational coefficients as unsigned Q32, rounded to nearest from nine decimals.
	localparam logic [63:0] Giga = 64'd1000000000;
	localparam logic [63:0] Half = 64'd500000000;
	localparam logic [CoefW-1:0] CoefA0 =
		CoefW'((64'd34287 << 32) + ((64'd466257736 << 32) + Half) / Giga);
	localparam logic [CoefW-1:0] CoefA1 =
		CoefW'((64'd2566 << 32) + ((64'd717546232 << 32) + Half) / Giga);
	localparam logic [CoefW-1:0] CoefA2 =
		CoefW'((64'd26 << 32) + ((64'd536637195 << 32) + Half) / Giga);
	localparam logic [CoefW-1:0] CoefB0 =
		CoefW'((64'd43656 << 32) + ((64'd157928129 << 32) + Half) / Giga);
	localparam logic [CoefW-1:0] CoefB1 =
		CoefW'((64'd12244 << 32) + ((64'd483955675 << 32) + Half) / Giga);
	localparam logic [CoefW-1:0] CoefB2 =
		CoefW'((64'd336 << 32) + ((64'd611376245 << 32) + Half) / Giga);

	// Quotient bits produced by the divider, one per stage.
	localparam int DivSteps  = 33;
	// Thirteen front stages, the divider, and the output register.
	localparam int NumStages = 13 + DivSteps + 1;

	// Clamp values of the Q16.16 result.
	localparam logic [TanW-1:0] TanMax = 32'h7FFFFFFF;
	localparam logic [TanW-1:0] TanMin = 32'h80000000;

endpackage

// ===== design/tangent_rational_octant.sv =====
// Top level of the tangent pipeline: octant reduction, rational approximation and
// a bit-per-stage divider. It depends on tro_pkg.

// The block returns tan(angle) for a signed Q8.24 angle in radians as a signed Q16.16
// value, with saturated set when the magnitude did not fit and was clamped (near the
// poles). Any angle is accepted, negative ones included; the angle is scaled by 4/pi,
// wrapped modulo 2*pi into one of eight octants, and tan(pi*u/4) of the reduced
// argument is formed as a degree-5 over degree-6 rational function, then inverted
// and negated as the octant requires. The design is a fully pipelined chain of 47
// register stages: thirteen for reduction and polynomial work (most products split
// into a pair of partial products), thirty-three for a restoring divider that settles
// one quotient bit per stage, and one output register. A request is taken every
// cycle while no finished result is held at the output, and results leave in request
// order. When the output stalls with a finished result the whole pipeline holds; the
// first stage still takes a request if it is empty, so no request is lost or repeated.
module tangent_rational_octant (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     angle_valid,
	output logic                     angle_stall,
	input  logic signed [31:0]       angle,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [31:0]       tangent,
	output logic                     saturated
);

	localparam int NS = tro_pkg::NumStages;
	localparam int DS = tro_pkg::DivSteps;

	// Floor of x*y/2^32 from the two partial products of y split at bit 32.
	function automatic logic [48:0] mq_sum(input logic [64:0] plo, input logic [48:0] phi);
		mq_sum = phi + 49'(plo[64:32]);
	endfunction

	logic [NS-1:0] vld_s;
	logic          en;
	logic          ld1;

	// The whole pipeline advances unless a finished result is held by the output side.
	assign en          = !vld_s[NS-1] || !result_stall;
	assign ld1         = en || !vld_s[0];
	assign angle_stall = !ld1;
	assign result_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld1) begin
				vld_s[0] <= angle_valid;
			end
			if (en) begin
				vld_s[NS-1:1] <= vld_s[NS-2:0];
			end
		end
	end

	// Stage 1: capture the request.
	logic [31:0] angle_s1;
	always_ff @(posedge clk) begin
		if (ld1 && angle_valid) begin
			angle_s1 <= angle;
		end
	end

	// Stage 2: magnitude times 4/pi as two partial products.
	logic        neg_c;
	logic [31:0] mag_c;
	logic [63:0] plo_s2;
	logic [60:0] phi_s2;
	logic        neg_s2;
	assign neg_c = angle_s1[31];
	assign mag_c = neg_c ? 32'(32'd0 - angle_s1) : angle_s1;

	// Stage 3: sum the partials and keep octant units with 40 fraction bits.
	logic [92:0] prod_c;
	logic [42:0] t_s3;
	logic        neg_s3;
	assign prod_c = (93'(phi_s2) << 32) + 93'(plo_s2);

	// Stage 4: wrap negative angles and fold odd octants into u = 1 - f.
	logic [42:0] tred_c;
	logic [40:0] u40_c;
	logic [32:0] u_s4;
	logic [2:0]  oct_s4;
	assign tred_c = neg_s3 ? 43'(43'd0 - t_s3) : t_s3;
	assign u40_c  = tred_c[40] ? (41'h100_0000_0000 - {1'b0, tred_c[39:0]})
		: {1'b0, tred_c[39:0]};

	// Stage 5: u squared.
	logic [65:0] uu_s5;
	logic [32:0] u_s5;
	logic [2:0]  oct_s5;

	// Stage 6: v = u*u; start v*a2 and form b2 - v.
	logic [32:0] v_c;
	logic [32:0] v_s6, u_s6;
	logic [2:0]  oct_s6;
	logic [47:0] s1_s6;
	logic [64:0] plo_s6;
	logic [48:0] phi_s6;
	assign v_c = uu_s5[64:32];

	// Stage 7: k1 = a1 - v*a2; start v*s1.
	logic [47:0] k1_c;
	logic [47:0] k1_s7;
	logic [32:0] v_s7, u_s7;
	logic [2:0]  oct_s7;
	logic [64:0] plo_s7;
	logic [48:0] phi_s7;
	assign k1_c = tro_pkg::CoefA1 - 48'(mq_sum(plo_s6, phi_s6));

	// Stage 8: s2 = b1 - v*s1; start v*k1.
	logic [47:0] s2_c;
	logic [47:0] s2_s8;
	logic [32:0] v_s8, u_s8;
	logic [2:0]  oct_s8;
	logic [64:0] plo_s8;
	logic [48:0] phi_s8;
	assign s2_c = tro_pkg::CoefB1 - 48'(mq_sum(plo_s7, phi_s7));

	// Stage 9: numerator polynomial A = a0 - v*k1; start v*s2.
	logic [47:0] acoef_c;
	logic [47:0] acoef_s9;
	logic [32:0] u_s9;
	logic [2:0]  oct_s9;
	logic [64:0] plo_s9;
	logic [48:0] phi_s9;
	assign acoef_c = tro_pkg::CoefA0 - 48'(mq_sum(plo_s8, phi_s8));

	// Stage 10: denominator B = b0 - v*s2; start u*A.
	logic [47:0] bcoef_c;
	logic [47:0] bcoef_s10;
	logic [2:0]  oct_s10;
	logic [64:0] plo_s10;
	logic [48:0] phi_s10;
	assign bcoef_c = tro_pkg::CoefB0 - 48'(mq_sum(plo_s9, phi_s9));

	// Stage 11: N = u*A.
	logic [47:0] num_s11, bcoef_s11;
	logic [2:0]  oct_s11;

	// Stage 12: pick the ratio or its reciprocal and add half the divisor for rounding.
	logic        recip_c;
	logic [64:0] dvd_s12;
	logic [47:0] dsr_s12;
	logic        neg_s12;
	assign recip_c = oct_s11[0] ^ oct_s11[1];

	// Stage 13: a quotient of 2^33 or more, a zero divisor included, saturates.
	logic [64:0] dvd_s13;
	logic [47:0] dsr_s13, rem_s13;
	logic        ovf_s13, neg_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_c;
			plo_s2 <= mag_c * tro_pkg::FourOverPiLo;
			phi_s2 <= 61'(mag_c) * 61'(tro_pkg::FourOverPiHi);

			t_s3   <= prod_c[86:44];
			neg_s3 <= neg_s2;

			u_s4   <= u40_c[40:8];
			oct_s4 <= tred_c[42:40];

			uu_s5  <= 66'(u_s4) * 66'(u_s4);
			u_s5   <= u_s4;
			oct_s5 <= oct_s4;

			v_s6   <= v_c;
			u_s6   <= u_s5;
			oct_s6 <= oct_s5;
			s1_s6  <= tro_pkg::CoefB2 - 48'(v_c);
			plo_s6 <= v_c * tro_pkg::CoefA2[31:0];
			phi_s6 <= 49'(v_c) * 49'(tro_pkg::CoefA2[47:32]);

			k1_s7  <= k1_c;
			v_s7   <= v_s6;
			u_s7   <= u_s6;
			oct_s7 <= oct_s6;
			plo_s7 <= v_s6 * s1_s6[31:0];
			phi_s7 <= 49'(v_s6) * 49'(s1_s6[47:32]);

			s2_s8  <= s2_c;
			v_s8   <= v_s7;
			u_s8   <= u_s7;
			oct_s8 <= oct_s7;
			plo_s8 <= v_s7 * k1_s7[31:0];
			phi_s8 <= 49'(v_s7) * 49'(k1_s7[47:32]);

			acoef_s9 <= acoef_c;
			u_s9     <= u_s8;
			oct_s9   <= oct_s8;
			plo_s9   <= v_s8 * s2_s8[31:0];
			phi_s9   <= 49'(v_s8) * 49'(s2_s8[47:32]);

			bcoef_s10 <= bcoef_c;
			oct_s10   <= oct_s9;
			plo_s10   <= u_s9 * acoef_s9[31:0];
			phi_s10   <= 49'(u_s9) * 49'(acoef_s9[47:32]);

			num_s11   <= 48'(mq_sum(plo_s10, phi_s10));
			bcoef_s11 <= bcoef_s10;
			oct_s11   <= oct_s10;

			if (recip_c) begin
				dvd_s12 <= ({17'd0, bcoef_s11} << 16) + 65'(num_s11[47:1]);
				dsr_s12 <= num_s11;
			end else begin
				dvd_s12 <= ({17'd0, num_s11} << 16) + 65'(bcoef_s11[47:1]);
				dsr_s12 <= bcoef_s11;
			end
			neg_s12 <= oct_s11[1];

			dvd_s13 <= dvd_s12;
			dsr_s13 <= dsr_s12;
			rem_s13 <= 48'(dvd_s12[64:33]);
			ovf_s13 <= (48'(dvd_s12[64:33]) >= dsr_s12);
			neg_s13 <= neg_s12;
		end
	end

	// Stages 14 to 46: restoring division, one quotient bit per stage, MSB first.
	logic [47:0] drem_s [DS];
	logic [47:0] ddsr_s [DS];
	logic [32:0] dlow_s [DS];
	logic [32:0] dquo_s [DS];
	logic        dovf_s [DS];
	logic        dneg_s [DS];

	for (genvar k = 0; k < DS; k++) begin : g_div
		logic [47:0] prem, pdsr;
		logic [32:0] plow, pquo;
		logic        povf, pneg;
		logic [48:0] trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign prem = rem_s13;
			assign pdsr = dsr_s13;
			assign plow = dvd_s13[32:0];
			assign pquo = '0;
			assign povf = ovf_s13;
			assign pneg = neg_s13;
		end else begin : g_next
			assign prem = drem_s[k-1];
			assign pdsr = ddsr_s[k-1];
			assign plow = dlow_s[k-1];
			assign pquo = dquo_s[k-1];
			assign povf = dovf_s[k-1];
			assign pneg = dneg_s[k-1];
		end
		assign trial = {prem, plow[DS-1-k]};
		assign ge    = trial >= {1'b0, pdsr};
		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[k] <= ge ? 48'(trial - {1'b0, pdsr}) : trial[47:0];
				dquo_s[k] <= {pquo[31:0], ge};
				ddsr_s[k] <= pdsr;
				dlow_s[k] <= plow;
				dovf_s[k] <= povf;
				dneg_s[k] <= pneg;
			end
		end
	end

	// Stage 47: apply the sign and clamp to the Q16.16 range.
	logic [32:0] mq_c;
	logic        mneg_c, movf_c;
	logic        sat_c;
	logic [31:0] res_c;
	logic [31:0] tan_s47;
	logic        sat_s47;
	assign mq_c   = dquo_s[DS-1];
	assign mneg_c = dneg_s[DS-1];
	assign movf_c = dovf_s[DS-1];

	always_comb begin
		if (mneg_c) begin
			sat_c = movf_c || (mq_c > 33'h080000000);
			res_c = sat_c ? tro_pkg::TanMin : 32'(33'd0 - mq_c);
		end else begin
			sat_c = movf_c || (mq_c > 33'h07FFFFFFF);
			res_c = sat_c ? tro_pkg::TanMax : mq_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tan_s47 <= res_c;
			sat_s47 <= sat_c;
		end
	end

	assign tangent   = tan_s47;
	assign saturated = sat_s47;

`ifndef SYNTH
	// The input side only waits while a finished result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> (result_valid && result_stall))
		else $error("input stalled without a held result");

	// A held pipeline neither drops nor invents requests past the first stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[NS-1:1]))
		else $error("pipeline valid bits moved while held");

	// A zero divisor must be caught by the overflow test.
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[12] && dsr_s13 == '0) |-> ovf_s13)
		else $error("zero divisor not flagged");

	// A saturated result carries one of the two clamp values.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |->
			(tangent == tro_pkg::TanMax || tangent == tro_pkg::TanMin))
		else $error("saturated result not clamped");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for tangent_rational_octant: drives angles through the valid/stall
// request channel and checks each tangent against a fixed-point predictor.
// Depends on tro_pkg and the tangent_rational_octant RTL.
`timescale 1ns / 1ps

module tb;

	logic               clk;
	logic               arst_n;
	logic               angle_valid;
	logic               angle_stall;
	logic signed [31:0] angle;
	logic               result_valid;
	logic               result_stall;
	logic signed [31:0] tangent;
	logic               saturated;

	tangent_rational_octant dut (
		.clk(clk), .arst_n(arst_n),
		.angle_valid(angle_valid), .angle_stall(angle_stall), .angle(angle),
		.result_valid(result_valid), .result_stall(result_stall),
		.tangent(tangent), .saturated(saturated)
	);

	// Expected tangent and flag, oldest first.
	logic [32:0] tan_expected[$];
	int          mismatches;
	int          rx_idle_pct;
	int          tx_idle_pct;
	bit          rx_hold;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Unsigned Q32 product, floor of x*y / 2^32.
	function automatic logic [63:0] q32_mul(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		p = x * y;
		return p[95:32];
	endfunction

	// Predicts {saturated, tangent} for one angle.
	function automatic logic [32:0] predict_tangent(input logic [31:0] a);
		logic [31:0]  mag;
		logic [95:0]  prod;
		logic [42:0]  t;
		logic [2:0]   oct;
		logic [40:0]  u40;
		logic [63:0]  u, v, k1, ac, s1, s2, bc, num, m;
		logic [127:0] q;
		logic         recip, negate, inf;
		mag = a[31] ? -a : a;
		prod = mag * {32'd0, tro_pkg::FourOverPiQ60};
		t = prod[86:44];
		if (a[31]) t = -t;
		oct = t[42:40];
		u40 = oct[0] ? (41'd1 << 40) - {1'b0, t[39:0]} : {1'b0, t[39:0]};
		u = 64'(u40 >> 8);
		v = q32_mul(u, u);
		k1 = 64'(tro_pkg::CoefA1) - q32_mul(v, 64'(tro_pkg::CoefA2));
		ac = 64'(tro_pkg::CoefA0) - q32_mul(v, k1);
		s1 = 64'(tro_pkg::CoefB2) - v;
		s2 = 64'(tro_pkg::CoefB1) - q32_mul(v, s1);
		bc = 64'(tro_pkg::CoefB0) - q32_mul(v, s2);
		num = q32_mul(u, ac);
		recip = oct[0] ^ oct[1];
		negate = oct[1];
		inf = 1'b0;
		m = 0;
		if (recip) begin
			if (num == 0) inf = 1'b1;
			else begin
				q = (({64'd0, bc} << 16) + (num >> 1)) / num;
				m = q[63:0];
			end
		end else begin
			q = (({64'd0, num} << 16) + (bc >> 1)) / bc;
			m = q[63:0];
		end
		if (negate) begin
			if (inf || m > 64'h80000000) return {1'b1, tro_pkg::TanMin};
			return {1'b0, 32'(-m)};
		end
		if (inf || m > 64'h7FFFFFFF) return {1'b1, tro_pkg::TanMax};
		return {1'b0, m[31:0]};
	endfunction

	// Offers one request and waits until it is accepted. Random gaps precede it;
	// valid drops only during a gap or when the sender stops.
	task automatic send_angle(input logic [31:0] a);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			angle_valid <= 1'b0;
			@(posedge clk);
		end
		angle_valid <= 1'b1;
		angle <= a;
		tan_expected.push_back(predict_tangent(a));
		do @(posedge clk); while (angle_stall);
	endtask

	// Receiver stall: random idling, or held high for a stretch when asked.
	always @(posedge clk) begin
		if (rx_hold) result_stall <= 1'b1;
		else result_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
	end

	// Result checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (tan_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", tangent);
			end else begin
				logic [32:0] want;
				want = tan_expected.pop_front();
				if (want != {saturated, tangent}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: tangent exp %h got %h, sat exp %b got %b",
							want[31:0], tangent, want[32], saturated);
				end
			end
		end
	end

	task automatic drain;
		angle_valid <= 1'b0;
		while (tan_expected.size() != 0) @(posedge clk);
	endtask

	// Extremes, octant boundaries, poles and negative angles.
	task automatic test_directed;
		logic [31:0] picks[$];
		picks = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'hFFFFFFFF,
			32'h00000001, 32'h00C90FDB, 32'h01921FB5, 32'h01921FB6, 32'h025B2F8F,
			32'h03243F6A, 32'h03243F6B, 32'h03ED4F45, 32'h04B65F20, 32'h057F6EFA,
			32'h06487ED5, 32'hFF36F025, 32'hFE6DE04B, 32'hFCDBC096, 32'h01921FB4,
			32'hFE6DE04A, 32'h12345678, 32'hAAAAAAAA, 32'h55555555};
		foreach (picks[i]) send_angle(picks[i]);
	endtask

	// Random angles: mostly within a few turns, some anywhere, some near poles.
	task automatic test_random(input int n);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: a = $urandom();
				1: a = 32'($signed($urandom_range(32'h0C90FDB6)) - 32'sh06487EDB);
				2: a = 32'h01921FB5 * $urandom_range(16) - 32'h0C90FDAA
					+ $urandom_range(8) - 4;
				default: a = 32'($signed($urandom_range(32'h03243F6A)) - 32'sh01921FB5);
			endcase
			send_angle(a);
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the pipe backs up.
	task automatic test_backpressure;
		rx_hold = 1'b1;
		fork
			test_random(80);
			begin
				repeat (150) @(posedge clk);
				rx_hold = 1'b0;
			end
		join
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		angle_valid = 1'b0;
		angle = '0;
		result_stall = 1'b0;
		rx_hold = 1'b0;
		mismatches = 0;
		rx_idle_pct = 22;
		tx_idle_pct = 22;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		// Sender pause until everything is back, then a stretch with no idling.
		rx_idle_pct = 0;
		tx_idle_pct = 0;
		test_random(120);
		rx_idle_pct = 22;
		tx_idle_pct = 22;
		test_random(300);
		test_backpressure();
		drain();
		repeat (tro_pkg::NumStages + 10) @(posedge clk);
		if (mismatches == 0 && tan_expected.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
